[rtl/core/bug1_navigation_controller_macros.svh]
// ----------------------------------------------------------------------------
// bug1_navigation_controller_macros
// assertion macros for the bug1 navigation controller
// ----------------------------------------------------------------------------
`ifndef BUG1_NAVIGATION_CONTROLLER_MACROS_SVH
`define BUG1_NAVIGATION_CONTROLLER_MACROS_SVH

// a condition implies a consequence at the same edge
`define ASSERT_IMPL(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// a condition implies a consequence at the next edge
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/b1nav_pkg.sv]
// ----------------------------------------------------------------------------
// b1nav_pkg
// types and constants shared by the bug1 navigation controller
// ----------------------------------------------------------------------------
`default_nettype none

package b1nav_pkg;

    localparam int PiQ12     = 12868;
    localparam int TwoPiQ12  = 25736;
    localparam int HalfPiQ12 = 6434;
    localparam int AtanLen   = 20;

    typedef enum logic [2:0] {
        MODE_REST   = 3'd0,
        MODE_GOAL   = 3'd1,
        MODE_LEAVE  = 3'd2,
        MODE_CIRCLE = 3'd3,
        MODE_RETURN = 3'd4
    } t_mode;

    typedef enum logic [0:0] {
        CFG_GOAL_X = 1'b0,
        CFG_GOAL_Y = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_DIST,
        SEQ_CORDIC,
        SEQ_DECIDE,
        SEQ_OUT
    } t_seq;

    typedef struct packed {
        logic        start;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
    } t_cordic_req;

    typedef struct packed {
        logic        done;
        logic signed [15:0] angle;
    } t_cordic_rsp;

    function automatic logic [12:0] atan_entry(input logic [4:0] idx);
        case (idx)
            5'd0:    atan_entry = 13'd3217;
            5'd1:    atan_entry = 13'd1899;
            5'd2:    atan_entry = 13'd1003;
            5'd3:    atan_entry = 13'd509;
            5'd4:    atan_entry = 13'd256;
            5'd5:    atan_entry = 13'd128;
            5'd6:    atan_entry = 13'd64;
            5'd7:    atan_entry = 13'd32;
            5'd8:    atan_entry = 13'd16;
            5'd9:    atan_entry = 13'd8;
            5'd10:   atan_entry = 13'd4;
            5'd11:   atan_entry = 13'd2;
            5'd12:   atan_entry = 13'd1;
            default: atan_entry = 13'd0;
        endcase
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
        if (v > 22'sd32767)       sat16 = 16'sh7fff;
        else if (v < -22'sd32768) sat16 = 16'sh8000;
        else                      sat16 = v[15:0];
    endfunction

endpackage

`default_nettype wire

[rtl/core/b1nav_if.sv]
// ----------------------------------------------------------------------------
// b1nav interfaces
// valid/ready channels for input, result and configuration words
// ----------------------------------------------------------------------------
`default_nettype none

interface b1nav_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [14:0] heading;
    logic [11:0]        sonar_front;
    logic [11:0]        sonar_left;
    logic [11:0]        sonar_right;
    modport source (output valid, pos_x, pos_y, heading, sonar_front, sonar_left,
                    sonar_right, input ready);
    modport sink (input valid, pos_x, pos_y, heading, sonar_front, sonar_left,
                  sonar_right, output ready);
endinterface

interface b1nav_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] turn_rate;
    logic [11:0]        forward_speed;
    logic [2:0]         nav_mode;
    modport source (output valid, turn_rate, forward_speed, nav_mode, input ready);
    modport sink (input valid, turn_rate, forward_speed, nav_mode, output ready);
endinterface

interface b1nav_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/b1nav_cordic.sv]
// ----------------------------------------------------------------------------
// b1nav_cordic
// iterative vectoring cordic, one micro-rotation per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module b1nav_cordic #(
    parameter int CORDIC_STEPS = 14
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  b1nav_pkg::t_cordic_req   i_req,
    output b1nav_pkg::t_cordic_rsp   o_rsp
);
    import b1nav_pkg::*;

    localparam int Steps = (CORDIC_STEPS < AtanLen) ? CORDIC_STEPS : AtanLen;

    // offsets below 2^16 times 16, plus gain growth
    logic signed [24:0] r_x, r_y, n_x, n_y;
    logic signed [15:0] r_z, n_z;
    logic [4:0]         r_i, n_i;
    logic               r_busy, n_busy, r_done, n_done;
    logic signed [24:0] xs, ys, x0, y0;
    logic signed [15:0] atv;

    always_comb begin
        xs     = r_x >>> r_i;
        ys     = r_y >>> r_i;
        atv    = 16'(signed'({3'b000, atan_entry(r_i)}));
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_i    = r_i;
        n_busy = r_busy;
        n_done = 1'b0;
        x0     = 25'(i_req.dx) <<< 4;
        y0     = 25'(i_req.dy) <<< 4;
        if (i_req.start) begin
            n_i = '0;
            if (i_req.dx == '0 && i_req.dy == '0) begin
                n_x = '0; n_y = '0; n_z = '0;
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                if (x0 < 0) begin
                    if (y0 >= 0) begin
                        n_x = y0; n_y = -x0; n_z = 16'(HalfPiQ12);
                    end else begin
                        n_x = -y0; n_y = x0; n_z = -16'(HalfPiQ12);
                    end
                end else begin
                    n_x = x0; n_y = y0; n_z = '0;
                end
            end
        end else if (r_busy) begin
            if (r_y >= 0) begin
                n_x = r_x + ys; n_y = r_y - xs; n_z = r_z + atv;
            end else begin
                n_x = r_x - ys; n_y = r_y + xs; n_z = r_z - atv;
            end
            n_i = r_i + 5'd1;
            if (r_i == 5'(Steps - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_i    <= n_i;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.angle = r_z;

endmodule

`default_nettype wire

[rtl/core/bug1_navigation_controller.sv]
// ----------------------------------------------------------------------------
// bug1_navigation_controller
// bug1 obstacle avoidance: mode sequencer, squared distances, cordic bearing
// ----------------------------------------------------------------------------
//  channel   dir   contents
//  i_in      in    pos_x pos_y heading sonar_front sonar_left sonar_right
//  o_out     out   turn_rate forward_speed nav_mode
//  i_cfg     in    index (0 goal_x, 1 goal_y) and 16-bit data
//
//  result follows these steps after a word is taken: three squared distances on
//  one shared multiplier, cordic load and one step per cycle, done, decide,
//  output; the cordic steps are skipped when the goal offset is zero
//  result sits in an output register; the next word is taken once it is read,
//  so a new word waits until the previous result has been read
//  synchronous active-low reset clears mode, stored points and held commands
`default_nettype none
`include "bug1_navigation_controller_macros.svh"

module bug1_navigation_controller #(
    parameter int CORDIC_STEPS = 14
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    b1nav_in_if.sink    i_in,
    b1nav_out_if.source o_out,
    b1nav_cfg_if.sink   i_cfg
);
    import b1nav_pkg::*;

    // configuration
    logic signed [15:0] r_goal_x, r_goal_y;

    // bug1 state
    t_mode              r_mode;
    logic signed [15:0] r_hit_x, r_hit_y, r_leave_x, r_leave_y;
    logic [31:0]        r_best;
    logic               r_flatch;
    logic [11:0]        r_prev_left;
    logic signed [15:0] r_turn;
    logic [11:0]        r_speed;

    // latched input word
    logic signed [15:0] r_px, r_py;
    logic signed [14:0] r_yaw;
    logic [11:0]        r_front, r_left, r_right;

    // sequencer
    t_seq               r_seq, n_seq;
    logic [2:0]         r_cnt;
    logic [32:0]        r_acc;
    logic [31:0]        r_dg, r_dh, r_dl;
    logic               r_ovalid;

    // shared squarer operand select
    logic signed [15:0] sel_ax;
    logic signed [16:0] diff;
    logic signed [33:0] dwide;
    logic [33:0]        prod;
    logic [33:0]        accsum;
    logic [31:0]        accsat;

    t_cordic_req        creq;
    t_cordic_rsp        crsp;

    b1nav_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (creq),
        .o_rsp  (crsp)
    );

    assign i_in.ready  = (r_seq == SEQ_IDLE) && !r_ovalid;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ovalid;
    assign o_out.turn_rate     = r_turn;
    assign o_out.forward_speed = r_speed;
    assign o_out.nav_mode      = r_mode;

    // step 0..5: dx,dy against goal, hit, leave
    always_comb begin
        case (r_cnt)
            3'd0, 3'd1: sel_ax = r_cnt[0] ? r_goal_y : r_goal_x;
            3'd2, 3'd3: sel_ax = r_cnt[0] ? r_hit_y : r_hit_x;
            default:    sel_ax = r_cnt[0] ? r_leave_y : r_leave_x;
        endcase
        diff   = (r_cnt[0] ? 17'(r_py) : 17'(r_px)) - 17'(sel_ax);
        dwide  = 34'(diff);
        prod   = $unsigned(dwide * dwide);
        accsum = {1'b0, r_acc} + prod;
        accsat = (accsum > 34'h0ffffffff) ? 32'hffffffff : accsum[31:0];
    end

    assign creq.start = (r_seq == SEQ_DIST) && (r_cnt == 3'd5);
    assign creq.dx    = 17'(r_goal_x) - 17'(r_px);
    assign creq.dy    = 17'(r_goal_y) - 17'(r_py);

    // decision datapath
    logic signed [16:0] err, aerr;
    logic signed [21:0] t3;
    logic signed [16:0] sp;
    logic signed [12:0] sdiff;
    logic signed [21:0] e_near, e_far;
    logic signed [15:0] g_turn;
    logic [11:0]        g_speed;

    always_comb begin
        err = 17'(crsp.angle) - 17'(r_yaw);
        if (err > 17'sd12868)       err = err - 17'(TwoPiQ12);
        else if (err < -17'sd12868) err = err + 17'(TwoPiQ12);
        aerr = (err < 0) ? -err : err;
        sp = 17'(PiQ12) - aerr;
        if (aerr > 17'sd819) begin
            t3 = 22'(err) * 22'sd3;
            t3 = (t3 < 0) ? -((-t3) >>> 1) : (t3 >>> 1);
            g_turn = sat16(t3);
            g_speed = (sp > 0) ? 12'(sp >>> 2) : 12'd0;
        end else begin
            t3 = (err < 0) ? -((22'(-err)) >>> 1) : (22'(err) >>> 1);
            g_turn = sat16(t3);
            g_speed = 12'd1024;
        end
        sdiff  = 13'({1'b0, r_left}) - 13'({1'b0, r_prev_left});
        e_near = 22'((22'({1'b0, r_left}) * 22'sd2 - 22'sd1024) * 22'sd5);
        e_far  = 22'((22'({1'b0, r_left}) * 22'sd2 - 22'sd819) * 22'sd5);
    end

    // sequencer
    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            SEQ_IDLE:   if (i_in.valid && i_in.ready) n_seq = SEQ_DIST;
            SEQ_DIST:   if (r_cnt == 3'd5) n_seq = SEQ_CORDIC;
            SEQ_CORDIC: if (crsp.done) n_seq = SEQ_DECIDE;
            SEQ_DECIDE: n_seq = SEQ_OUT;
            SEQ_OUT:    n_seq = SEQ_IDLE;
            default:    n_seq = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SEQ_IDLE;
            r_cnt       <= '0;
            r_ovalid    <= 1'b0;
            r_goal_x    <= '0;
            r_goal_y    <= '0;
            r_mode      <= MODE_REST;
            r_hit_x     <= '0;
            r_hit_y     <= '0;
            r_leave_x   <= '0;
            r_leave_y   <= '0;
            r_best      <= '0;
            r_flatch    <= 1'b0;
            r_prev_left <= '0;
            r_turn      <= '0;
            r_speed     <= '0;
        end else begin
            r_seq <= n_seq;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_GOAL_X: r_goal_x <= i_cfg.data;
                    CFG_GOAL_Y: r_goal_y <= i_cfg.data;
                    default:    ;
                endcase
            end
            if (o_out.valid && o_out.ready) r_ovalid <= 1'b0;
            case (r_seq)
                SEQ_IDLE: begin
                    r_cnt <= '0;
                    r_acc <= '0;
                    r_px  <= i_in.pos_x;
                    r_py  <= i_in.pos_y;
                    r_yaw <= i_in.heading;
                    r_front <= i_in.sonar_front;
                    r_left  <= i_in.sonar_left;
                    r_right <= i_in.sonar_right;
                end
                SEQ_DIST: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt[0]) begin
                        r_acc <= '0;
                        case (r_cnt[2:1])
                            2'd0:    r_dg <= accsat;
                            2'd1:    r_dh <= accsat;
                            default: r_dl <= accsat;
                        endcase
                    end else begin
                        r_acc <= {1'b0, accsat};
                    end
                end
                SEQ_DECIDE: begin
                    case (r_mode)
                        MODE_GOAL: begin
                            if (r_dg <= 32'd2621) begin
                                r_turn <= '0; r_speed <= '0; r_mode <= MODE_REST;
                            end else begin
                                r_turn <= g_turn; r_speed <= g_speed;
                                if (r_front > 12'd0 && r_front < 12'd819) begin
                                    r_hit_x <= r_px; r_hit_y <= r_py;
                                    r_mode <= MODE_LEAVE;
                                end
                            end
                        end
                        MODE_LEAVE, MODE_CIRCLE, MODE_RETURN: begin
                            // wall follower
                            if (r_front < 12'd512 && r_front != 0 && r_left == 0
                                && r_right == 0 && !r_flatch) begin
                                r_turn <= -16'sd2048; r_speed <= 12'd512;
                            end else if (r_front != 0 && r_left != 0) begin
                                r_turn <= -16'sd3072; r_speed <= 12'd512;
                            end else if (r_left != 0 && r_left <= 12'd409) begin
                                r_turn <= sat16((sdiff > 0) ? -e_near : e_near);
                                r_speed <= 12'd2048;
                                r_flatch <= 1'b1;
                            end else if (r_left >= 12'd461) begin
                                r_turn <= sat16((sdiff < 0) ? -e_far : e_far);
                                r_speed <= 12'd2048;
                            end else if (r_front == 0 && r_left == 0) begin
                                r_turn <= 16'sd6144;
                            end
                            r_prev_left <= r_left;
                            if (r_mode == MODE_LEAVE) begin
                                if (r_dh > 32'd262144) begin
                                    r_best <= r_dg; r_mode <= MODE_CIRCLE;
                                end
                            end else if (r_mode == MODE_CIRCLE) begin
                                if (r_dg < r_best) begin
                                    r_leave_x <= r_px; r_leave_y <= r_py;
                                    r_best <= r_dg;
                                end
                                if (r_dh <= 32'd167772) r_mode <= MODE_RETURN;
                            end else begin
                                if (r_dl <= 32'd94371) r_mode <= MODE_REST;
                            end
                        end
                        default: begin
                            r_flatch <= 1'b0;
                            r_mode <= (r_dg > 32'd10485) ? MODE_GOAL : MODE_REST;
                        end
                    endcase
                end
                SEQ_OUT: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    // no new word while a result is pending
    `ASSERT_IMPL(a_no_accept_pending, i_clk, i_rst_n, r_ovalid, !i_in.ready)
    // the output step always raises the result valid
    `ASSERT_NEXT(a_out_after_seq, i_clk, i_rst_n, r_seq == SEQ_OUT, r_ovalid)
    // cordic reports done only while the sequencer waits for it
    `ASSERT_IMPL(a_cordic_done, i_clk, i_rst_n, crsp.done, r_seq == SEQ_CORDIC)

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bug1 navigation controller: a cycle-free
// predictor of the five navigation modes is checked against every output word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import b1nav_pkg::*;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [14:0] heading;
        logic [11:0]        front;
        logic [11:0]        left;
        logic [11:0]        right;
    } t_tick;

    typedef struct packed {
        logic signed [15:0] turn;
        logic [11:0]        speed;
        logic [2:0]         mode;
    } t_cmd;

    localparam int StepCount  = 14;
    localparam int IdleLimit  = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #6 i_clk = ~i_clk;

    b1nav_in_if  in_ch();
    b1nav_out_if out_ch();
    b1nav_cfg_if cfg_ch();

    bug1_navigation_controller #(.CORDIC_STEPS(StepCount)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // predictor state, mirrors the block's registers
    longint nav_goal_x, nav_goal_y;
    logic [2:0] nav_mode;
    longint hit_px, hit_py, leave_px, leave_py;
    longint best_d2;
    bit latch_front;
    longint last_left;
    longint hold_turn, hold_speed;

    t_tick pending_ticks[$];
    t_cmd  expected_cmds[$];
    int    fail_count = 0;
    bit    hold_sender = 1'b0;

    // a pending configuration write, driven by the initial block
    logic       cfg_req = 1'b0;
    t_cfg_idx   cfg_req_idx;
    logic [15:0] cfg_req_data;

    function automatic void queue_tick(t_tick t);
        pending_ticks = {pending_ticks, t};
    endfunction

    function automatic void record_cmd(t_cmd c);
        expected_cmds = {expected_cmds, c};
    endfunction

    function automatic longint sat_16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint squared_gap(longint ax, longint ay, longint bx, longint by);
        longint dx, dy, d;
        dx = ax - bx;
        dy = ay - by;
        d = dx * dx + dy * dy;
        return (d > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : d;
    endfunction

    function automatic longint arc_table(int i);
        case (i)
            0: return 3217;  1: return 1899;  2: return 1003;  3: return 509;
            4: return 256;   5: return 128;   6: return 64;    7: return 32;
            8: return 16;    9: return 8;     10: return 4;    11: return 2;
            12: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic longint bearing(longint y, longint x);
        longint z, t, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        x = x * 16;
        y = y * 16;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = PiQ12 / 2;
            end else begin
                t = x; x = -y; y = t; z = -(PiQ12 / 2);
            end
        end
        for (int i = 0; i < StepCount && i < 20; i++) begin
            xs = floor_sh(x, i);
            ys = floor_sh(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += arc_table(i);
            end else begin
                x -= ys; y += xs; z -= arc_table(i);
            end
        end
        return z;
    endfunction

    function automatic void steer_to_goal(longint px, longint py, longint yaw);
        longint th, d, ad, s;
        th = bearing(nav_goal_y - py, nav_goal_x - px);
        d = th - yaw;
        if (d > PiQ12) d -= TwoPiQ12;
        else if (d < -PiQ12) d += TwoPiQ12;
        ad = (d < 0) ? -d : d;
        if (ad > 819) begin
            s = PiQ12 - ad;
            hold_turn = sat_16((d * 3) / 2);
            hold_speed = (s > 0) ? s / 4 : 0;
        end else begin
            hold_turn = sat_16(d / 2);
            hold_speed = 1024;
        end
    endfunction

    function automatic void track_wall(longint f, longint l, longint r);
        longint diff, e;
        diff = l - last_left;
        if (f < 512 && f != 0 && l == 0 && r == 0 && !latch_front) begin
            hold_turn = -2048; hold_speed = 512;
        end else if (f != 0 && l != 0) begin
            hold_turn = -3072; hold_speed = 512;
        end else if (l != 0 && l <= 409) begin
            e = (l * 2 - 1024) * 5;
            hold_turn = sat_16(diff > 0 ? -e : e);
            hold_speed = 2048;
            latch_front = 1'b1;
        end else if (l >= 461) begin
            e = (l * 2 - 819) * 5;
            hold_turn = sat_16(diff < 0 ? -e : e);
            hold_speed = 2048;
        end else if (f == 0 && l == 0) begin
            hold_turn = 6144;
        end
        last_left = l;
    endfunction

    // one control tick of the navigator; returns the command word it yields
    function automatic t_cmd navigate(t_tick t);
        longint px, py, dg, dh, dl;
        t_cmd c;
        px = t.pos_x;
        py = t.pos_y;
        dg = squared_gap(px, py, nav_goal_x, nav_goal_y);
        dh = squared_gap(px, py, hit_px, hit_py);
        dl = squared_gap(px, py, leave_px, leave_py);
        case (nav_mode)
            MODE_GOAL: begin
                steer_to_goal(px, py, longint'(t.heading));
                if (dg <= 2621) begin
                    hold_turn = 0; hold_speed = 0; nav_mode = MODE_REST;
                end else if (t.front > 0 && t.front < 819) begin
                    hit_px = px; hit_py = py; nav_mode = MODE_LEAVE;
                end
            end
            MODE_LEAVE: begin
                track_wall(t.front, t.left, t.right);
                if (dh > 262144) begin
                    best_d2 = dg; nav_mode = MODE_CIRCLE;
                end
            end
            MODE_CIRCLE: begin
                track_wall(t.front, t.left, t.right);
                if (dg < best_d2) begin
                    leave_px = px; leave_py = py; best_d2 = dg;
                end
                if (dh <= 167772) nav_mode = MODE_RETURN;
            end
            MODE_RETURN: begin
                track_wall(t.front, t.left, t.right);
                if (dl <= 94371) nav_mode = MODE_REST;
            end
            default: begin
                latch_front = 1'b0;
                nav_mode = (dg > 10485) ? MODE_GOAL : MODE_REST;
            end
        endcase
        c.turn = hold_turn[15:0];
        c.speed = hold_speed[11:0];
        c.mode = nav_mode;
        return c;
    endfunction

    // ---------------- input driver: bursts and gaps ----------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                // word accepted: predict its result now
                record_cmd(navigate(pending_ticks.pop_front()));
            end
            if (in_ch.valid && !in_ch.ready) begin
                // hold the word until taken
            end else if (gap_left > 0) begin
                in_ch.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_ticks.size() > 0 && !hold_sender && !cfg_req) begin
                in_ch.valid <= 1'b1;
                {in_ch.pos_x, in_ch.pos_y, in_ch.heading, in_ch.sonar_front,
                 in_ch.sonar_left, in_ch.sonar_right} <= pending_ticks[0];
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------- configuration driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_ch.valid <= 1'b0;
        end else if (cfg_ch.valid && cfg_ch.ready) begin
            if (cfg_ch.index == CFG_GOAL_X) nav_goal_x <= longint'($signed(cfg_ch.data));
            else nav_goal_y <= longint'($signed(cfg_ch.data));
            cfg_ch.valid <= 1'b0;
            cfg_req <= 1'b0;
        end else if (cfg_req && !in_ch.valid) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= cfg_req_idx;
            cfg_ch.data <= cfg_req_data;
        end
    end

    // ---------------- monitor with stall pattern ----------------
    int stall_phase = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_cmds.size() == 0) begin
                    $display("%0t: unexpected word turn=%0d speed=%0d mode=%0d", $time,
                             out_ch.turn_rate, out_ch.forward_speed, out_ch.nav_mode);
                    fail_count++;
                end else begin
                    t_cmd e;
                    e = expected_cmds.pop_front();
                    if (out_ch.turn_rate !== e.turn) begin
                        $display("%0t: turn_rate expected %0d actual %0d", $time,
                                 e.turn, out_ch.turn_rate);
                        fail_count++;
                    end
                    if (out_ch.forward_speed !== e.speed) begin
                        $display("%0t: forward_speed expected %0d actual %0d", $time,
                                 e.speed, out_ch.forward_speed);
                        fail_count++;
                    end
                    if (out_ch.nav_mode !== e.mode) begin
                        $display("%0t: nav_mode expected %0d actual %0d", $time,
                                 e.mode, out_ch.nav_mode);
                        fail_count++;
                    end
                end
            end
            // stall pattern: long free runs, then bursts of random stalls
            stall_phase <= (stall_phase + 1) % 400;
            if (stall_phase < 150) out_ch.ready <= 1'b1;
            else out_ch.ready <= ($urandom_range(0, 3) != 0) && ($urandom_range(0, 30) != 0);
        end
    end

    // ---------------- watchdog ----------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic t_tick any_tick();
        t_tick t;
        t.pos_x = 16'($urandom);
        t.pos_y = 16'($urandom);
        t.heading = 15'($urandom_range(0, 2 * 12868) - 12868);
        if ($urandom_range(0, 9) == 0) t.heading = 15'($urandom);
        t.front = ($urandom_range(0, 3) == 0) ? 12'd0 : 12'($urandom);
        t.left = ($urandom_range(0, 3) == 0) ? 12'd0 : 12'($urandom);
        t.right = ($urandom_range(0, 3) == 0) ? 12'd0 : 12'($urandom);
        return t;
    endfunction

    // a plausible bug1 episode: drive toward goal, hit, circle, come back
    task automatic queue_episode();
        longint gx, gy, x, y, r, ang;
        t_tick t;
        int n;
        gx = nav_goal_x;
        gy = nav_goal_y;
        x = gx + $urandom_range(0, 8000) - 4000;
        y = gy + $urandom_range(0, 8000) - 4000;
        n = $urandom_range(3, 6);
        for (int i = 0; i < n; i++) begin
            t.pos_x = 16'(x); t.pos_y = 16'(y);
            t.heading = 15'($urandom_range(0, 2 * 12868) - 12868);
            t.front = (i == n - 1) ? 12'($urandom_range(1, 818)) : 12'($urandom_range(0, 4095));
            t.left = $urandom_range(0, 1) ? 12'd0 : 12'($urandom_range(0, 4095));
            t.right = $urandom_range(0, 1) ? 12'd0 : 12'($urandom);
            if (i != n - 1 && t.front > 0 && t.front < 819) t.front = 0;
            queue_tick(t);
        end
        // circle around the hit point, radius about 0.7 m
        r = 700;
        n = $urandom_range(8, 20);
        for (int i = 0; i <= n + 4; i++) begin
            ang = (i * 6283) / n;
            t.pos_x = 16'(x + (r * ($urandom_range(0, 1) ? 1 : -1) * (ang % 2000)) / 2000
                      + ((i == 0 || i >= n) ? 0 : 700));
            t.pos_y = 16'(y + ((i == 0 || i >= n) ? $urandom_range(0, 100)
                                                  : ((ang / 3) % 900)));
            t.heading = 15'($urandom_range(0, 2 * 12868) - 12868);
            t.front = ($urandom_range(0, 2) == 0) ? 12'd0 : 12'($urandom_range(1, 1200));
            t.left = ($urandom_range(0, 4) == 0) ? 12'd0 : 12'($urandom_range(300, 600));
            t.right = ($urandom_range(0, 1) == 0) ? 12'd0 : 12'($urandom);
            queue_tick(t);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        // registers change only with the block idle
        wait (pending_ticks.size() == 0 && expected_cmds.size() == 0 && !in_ch.valid);
        repeat (40) @(posedge i_clk);
        cfg_req_idx = idx;
        cfg_req_data = val;
        cfg_req = 1'b1;
        wait (!cfg_req);
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        wait (pending_ticks.size() == 0 && expected_cmds.size() == 0);
    endtask

    initial begin
        t_tick t;
        in_ch.valid = 1'b0;
        in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.heading = '0;
        in_ch.sonar_front = '0; in_ch.sonar_left = '0; in_ch.sonar_right = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
        nav_goal_x = 0; nav_goal_y = 0; nav_mode = MODE_REST;
        hit_px = 0; hit_py = 0; leave_px = 0; leave_py = 0; best_d2 = 0;
        latch_front = 0; last_left = 0; hold_turn = 0; hold_speed = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: goal at origin, at-goal rest, extremes of every field
        t = '0;
        queue_tick(t);
        t.pos_x = 16'sh7fff; t.pos_y = 16'sh8000; t.heading = 15'sd12868;
        queue_tick(t);
        t.heading = -15'sd12868; t.front = 12'd818;
        queue_tick(t);
        t.front = 0; t.left = 0; t.right = 0;               // no echo anywhere
        queue_tick(t);
        t.front = 12'd300; t.right = 0;                     // close front, free sides
        queue_tick(t);
        t.front = 12'd4095; t.left = 12'd4095; t.right = 12'd4095;
        queue_tick(t);
        t.front = 0; t.left = 12'd409;                      // near wall
        queue_tick(t);
        t.left = 12'd430;                                   // between near and far
        queue_tick(t);
        t.left = 12'd461;                                   // far wall
        queue_tick(t);
        t.pos_x = 0; t.pos_y = 0; t.left = 12'd200;         // back near hit
        queue_tick(t);
        t.heading = 15'h4000;                               // heading beyond -pi
        queue_tick(t);
        t.heading = 15'h3fff;
        queue_tick(t);
        wait_drained();

        // goal extremes and a few random goals with episodes
        for (int phase = 0; phase < 6; phase++) begin
            logic [15:0] gx, gy;
            case (phase)
                0: begin gx = 16'h7fff; gy = 16'h8000; end
                1: begin gx = 16'h8000; gy = 16'h7fff; end
                2: begin gx = 16'h0000; gy = 16'h0000; end
                default: begin gx = 16'($urandom); gy = 16'($urandom); end
            endcase
            write_reg(CFG_GOAL_X, gx);
            write_reg(CFG_GOAL_Y, gy);
            for (int k = 0; k < 2; k++) queue_episode();
            for (int k = 0; k < 16; k++) queue_tick(any_tick());
            if (phase == 3) begin
                // pause the sender until every result is back
                wait (pending_ticks.size() < 40);
                hold_sender = 1'b1;
                wait (expected_cmds.size() == 0 && !in_ch.valid);
                repeat (50) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            wait_drained();
        end
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && expected_cmds.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/b1nav_pkg.sv
rtl/core/b1nav_if.sv
rtl/core/b1nav_cordic.sv
rtl/core/bug1_navigation_controller.sv
tb/tb_top.sv
